// ===== rtl/erd_pkg.sv =====
// ----------------------------------------------------------------------------
// erd_pkg
// Shared types, constants and helper functions for the run list decoder.
// ----------------------------------------------------------------------------
package erd_pkg;

	// bytes kept from one size field, 1 to 8
	localparam int unsigned FIELD_BYTES = 8;

	// configuration register indexes
	localparam logic REG_BYTES_PER_CLUSTER = 1'b0;

	// register reset value
	localparam logic [21:0] BPC_RESET = 22'd4096;

	// header byte nibble masks
	localparam logic [7:0] LEN_NIBBLE_MASK   = 8'h0F;
	localparam logic [7:0] DELTA_NIBBLE_MASK = 8'hF0;

	// command from the front part to the back part
	typedef struct packed {
		logic        is_end;
		logic        sparse;
		logic        overlong;
		logic [3:0]  delta_size;
		logic [63:0] length;
		logic [63:0] delta;
	} cmd_t;

	// one result transaction
	typedef struct packed {
		logic [63:0] start_cluster;
		logic [63:0] length_bytes;
		logic        is_sparse;
		logic        list_end;
		logic [15:0] frag_count;
		logic        has_sparse;
		logic [63:0] total_clusters;
		logic        too_long;
	} res_t;

	// drop one byte into its lane, lanes past FIELD_BYTES are discarded
	function automatic logic [63:0] collect_byte(input logic [63:0] acc,
			input logic [3:0] pos, input logic [7:0] b);
		logic [63:0] res;
		res = acc;
		for (int i = 0; i < 8; i++) begin
			if (i < FIELD_BYTES && pos == 4'(i)) begin
				res[8*i +: 8] = res[8*i +: 8] | b;
			end
		end
		return res;
	endfunction

	// sign extend a delta from its top kept byte
	function automatic logic [63:0] sign_extend(input logic [63:0] acc,
			input logic [3:0] size);
		logic [63:0] res;
		logic [3:0]  kept;
		res = acc;
		kept = (size > 4'(FIELD_BYTES)) ? 4'(FIELD_BYTES) : size;
		for (int i = 1; i < 8; i++) begin
			if (kept == 4'(i) && acc[8*i-1]) begin
				res = acc | (~64'd0 << (8*i));
			end
		end
		return res;
	endfunction

endpackage

// ===== rtl/erd_queue.sv =====
// ----------------------------------------------------------------------------
// erd_queue
// Small first-in first-out queue of register entries with occupancy count.
// ----------------------------------------------------------------------------
module erd_queue #(
	parameter int unsigned W  = 8,
	parameter int unsigned AW = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  logic [W-1:0]  wr_data,
	input  logic          rd_en,
	output logic [W-1:0]  rd_data,
	output logic          empty,
	output logic          full,
	output logic [AW:0]   count
);

	localparam int unsigned DEPTH = 1 << AW;

	logic [W-1:0]  mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [AW:0]   count_q;
	logic          do_wr;
	logic          do_rd;

	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign rd_data = mem_q[rd_ptr_q];
	assign empty   = (count_q == '0);
	assign full    = (count_q == (AW+1)'(DEPTH));
	assign count   = count_q;

endmodule

// ===== rtl/erd_front.sv =====
// ----------------------------------------------------------------------------
// erd_front
// Takes list bytes, parses headers and gathers field bytes into commands.
// ----------------------------------------------------------------------------
module erd_front
	import erd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] list_byte,
	output logic       full,
	output logic       cmd_push,
	output cmd_t       cmd_data,
	input  logic       cmd_full
);

	localparam logic [1:0] PH_HEADER = 2'd0;
	localparam logic [1:0] PH_LENGTH = 2'd1;
	localparam logic [1:0] PH_DELTA  = 2'd2;

	logic [1:0]  phase_q;
	logic [3:0]  length_size_q;
	logic [3:0]  delta_size_q;
	logic [3:0]  pos_q;
	logic [63:0] length_acc_q;
	logic [63:0] delta_acc_q;
	logic        overlong_q;

	logic        accept;
	logic [3:0]  pos_next;
	logic [3:0]  hdr_len;
	logic [3:0]  hdr_delta;
	logic [63:0] length_next;
	logic [63:0] delta_next;
	logic        hdr_overlong;

	assign full     = cmd_full;
	assign accept   = push && !cmd_full;
	assign pos_next = pos_q + 1'b1;

	// header nibbles
	assign hdr_len      = 4'(list_byte & LEN_NIBBLE_MASK);
	assign hdr_delta    = 4'((list_byte & DELTA_NIBBLE_MASK) >> 4);
	assign hdr_overlong = (hdr_len > 4'(FIELD_BYTES)) || (hdr_delta > 4'(FIELD_BYTES));

	// accumulators with this byte merged in
	assign length_next = collect_byte(length_acc_q, pos_q, list_byte);
	assign delta_next  = collect_byte(delta_acc_q, pos_q, list_byte);

	// command generation
	always_comb begin
		cmd_push            = 1'b0;
		cmd_data.is_end     = 1'b0;
		cmd_data.sparse     = (delta_size_q == 4'd0);
		cmd_data.overlong   = overlong_q;
		cmd_data.delta_size = delta_size_q;
		cmd_data.length     = length_acc_q;
		cmd_data.delta      = delta_acc_q;
		case (phase_q)
			PH_HEADER: begin
				if (accept && list_byte == 8'd0) begin
					cmd_push        = 1'b1;
					cmd_data.is_end = 1'b1;
				end
			end
			PH_LENGTH: begin
				cmd_data.length = length_next;
				if (accept && pos_next >= length_size_q && delta_size_q == 4'd0) begin
					cmd_push = 1'b1;
				end
			end
			PH_DELTA: begin
				cmd_data.delta = delta_next;
				if (accept && pos_next >= delta_size_q) begin
					cmd_push = 1'b1;
				end
			end
			default: begin
				cmd_push = 1'b0;
			end
		endcase
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			length_size_q <= '0;
			delta_size_q  <= '0;
			pos_q         <= '0;
			length_acc_q  <= '0;
			delta_acc_q   <= '0;
			overlong_q    <= 1'b0;
		end else if (accept) begin
			case (phase_q)
				PH_HEADER: begin
					pos_q        <= '0;
					length_acc_q <= '0;
					delta_acc_q  <= '0;
					if (list_byte == 8'd0) begin
						length_size_q <= '0;
						delta_size_q  <= '0;
						overlong_q    <= 1'b0;
					end else begin
						length_size_q <= hdr_len;
						delta_size_q  <= hdr_delta;
						overlong_q    <= overlong_q || hdr_overlong;
						phase_q       <= (hdr_len != 4'd0) ? PH_LENGTH : PH_DELTA;
					end
				end
				PH_LENGTH: begin
					length_acc_q <= length_next;
					pos_q        <= pos_next;
					if (pos_next >= length_size_q) begin
						pos_q   <= '0;
						phase_q <= (delta_size_q != 4'd0) ? PH_DELTA : PH_HEADER;
					end
				end
				PH_DELTA: begin
					delta_acc_q <= delta_next;
					pos_q       <= pos_next;
					if (pos_next >= delta_size_q) begin
						pos_q   <= '0;
						phase_q <= PH_HEADER;
					end
				end
				default: begin
					phase_q <= PH_HEADER;
				end
			endcase
		end
	end

endmodule

// ===== rtl/erd_back.sv =====
// ----------------------------------------------------------------------------
// erd_back
// Executes run commands: scales lengths, sums deltas and keeps list totals.
// ----------------------------------------------------------------------------
module erd_back
	import erd_pkg::*;
#(
	parameter int unsigned RES_AW = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic [21:0]     bytes_per_cluster,
	input  logic            cmd_empty,
	input  cmd_t            cmd_data,
	output logic            cmd_pop,
	input  logic [RES_AW:0] res_count,
	output logic            res_push,
	output res_t            res_data
);

	localparam int unsigned RES_DEPTH = 1 << RES_AW;

	// stage 1 registers
	logic        valid_s1;
	logic        is_end_s1;
	logic        sparse_s1;
	logic        overlong_s1;
	logic [63:0] length_s1;
	logic [63:0] delta_s1;
	logic [53:0] prod_lo_s1;
	logic [31:0] prod_hi_s1;

	// running list state
	logic [63:0] cluster_sum_q;
	logic [15:0] frag_q;
	logic        sparse_seen_q;
	logic [63:0] total_q;

	logic [RES_AW+1:0] in_flight;
	logic [53:0]       prod_hi_full;
	logic [63:0]       len_bytes;
	logic [63:0]       sum_next;
	logic [15:0]       frag_next;
	logic              seen_next;
	logic [63:0]       total_next;

	// pop only with a result slot guaranteed
	assign in_flight = (RES_AW+2)'(res_count) + (RES_AW+2)'(valid_s1);
	assign cmd_pop   = !cmd_empty && (in_flight < (RES_AW+2)'(RES_DEPTH));

	// split 64x22 multiply into two 32x22 partial products
	assign prod_hi_full = 54'(cmd_data.length[63:32]) * 54'(bytes_per_cluster);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			is_end_s1   <= cmd_data.is_end;
			sparse_s1   <= cmd_data.sparse;
			overlong_s1 <= cmd_data.overlong;
			length_s1   <= cmd_data.length;
			delta_s1    <= cmd_data.sparse ? 64'd0
				: sign_extend(cmd_data.delta, cmd_data.delta_size);
			prod_lo_s1  <= 54'(cmd_data.length[31:0]) * 54'(bytes_per_cluster);
			prod_hi_s1  <= prod_hi_full[31:0];
		end
	end

	// combine partial products and update totals
	assign len_bytes  = {prod_hi_s1, 32'd0} + {10'd0, prod_lo_s1};
	assign sum_next   = cluster_sum_q + delta_s1;
	assign frag_next  = (!sparse_s1 && delta_s1 != 64'd0 && frag_q != 16'hFFFF)
		? frag_q + 1'b1 : frag_q;
	assign seen_next  = sparse_seen_q || sparse_s1;
	assign total_next = total_q + length_s1;

	// result transaction
	always_comb begin
		res_push = valid_s1;
		if (is_end_s1) begin
			res_data.start_cluster  = 64'd0;
			res_data.length_bytes   = 64'd0;
			res_data.is_sparse      = 1'b0;
			res_data.list_end       = 1'b1;
			res_data.frag_count     = frag_q;
			res_data.has_sparse     = sparse_seen_q;
			res_data.total_clusters = total_q;
		end else begin
			res_data.start_cluster  = sum_next;
			res_data.length_bytes   = len_bytes;
			res_data.is_sparse      = sparse_s1;
			res_data.list_end       = 1'b0;
			res_data.frag_count     = frag_next;
			res_data.has_sparse     = seen_next;
			res_data.total_clusters = total_next;
		end
		res_data.too_long = overlong_s1;
	end

	// running state, cleared by the terminator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cluster_sum_q <= '0;
			frag_q        <= '0;
			sparse_seen_q <= 1'b0;
			total_q       <= '0;
		end else if (valid_s1) begin
			if (is_end_s1) begin
				cluster_sum_q <= '0;
				frag_q        <= '0;
				sparse_seen_q <= 1'b0;
				total_q       <= '0;
			end else begin
				cluster_sum_q <= sum_next;
				frag_q        <= frag_next;
				sparse_seen_q <= seen_next;
				total_q       <= total_next;
			end
		end
	end

endmodule

// ===== rtl/extent_runlist_decoder.sv =====
// ----------------------------------------------------------------------------
// extent_runlist_decoder
// Run list decoder: one list byte per cycle unless full; a result per run and end.
// ----------------------------------------------------------------------------
// Throughput: one list byte per cycle while the command queue is not full.
// Path: the byte that completes a run (or the terminator) becomes a command that
// passes through the command queue, the partial-product stage of the length
// multiplier and the result queue before it shows on the result ports.
// Reset: all list state cleared, bytes_per_cluster set to 4096, both queues empty.
module extent_runlist_decoder
	import erd_pkg::*;
#(
	parameter int unsigned CMD_AW = 2,
	parameter int unsigned RES_AW = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	// byte input
	input  logic               push,
	output logic               full,
	input  logic [7:0]         list_byte,
	// results
	output logic               empty,
	input  logic               pop,
	output logic signed [63:0] run_start_cluster,
	output logic [63:0]        run_length_bytes,
	output logic               run_is_sparse,
	output logic               list_end,
	output logic [15:0]        fragment_count,
	output logic               list_has_sparse,
	output logic [63:0]        total_clusters,
	output logic               field_too_long,
	// configuration
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic [21:0] bpc_q;
	logic        cfg_sel;

	logic        cmd_push;
	cmd_t        cmd_wdata;
	cmd_t        cmd_rdata;
	logic        cmd_full;
	logic        cmd_empty;
	logic        cmd_pop;
	logic [CMD_AW:0] cmd_count;

	logic        res_push;
	res_t        res_wdata;
	res_t        res_rdata;
	logic        res_full;
	logic [RES_AW:0] res_count;

	// configuration register
	assign pready  = 1'b1;
	assign cfg_sel = (paddr[2] == REG_BYTES_PER_CLUSTER) && (paddr[1:0] == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpc_q <= BPC_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_BYTES_PER_CLUSTER) begin
			bpc_q <= pwdata[21:0];
		end
	end

	assign prdata = cfg_sel ? {10'd0, bpc_q} : 32'd0;

	// front part
	erd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.list_byte (list_byte),
		.full      (full),
		.cmd_push  (cmd_push),
		.cmd_data  (cmd_wdata),
		.cmd_full  (cmd_full)
	);

	// command queue between front and back
	erd_queue #(
		.W  ($bits(cmd_t)),
		.AW (CMD_AW)
	) u_cmd_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_wdata),
		.rd_en   (cmd_pop),
		.rd_data (cmd_rdata),
		.empty   (cmd_empty),
		.full    (cmd_full),
		.count   (cmd_count)
	);

	// back part
	erd_back #(
		.RES_AW (RES_AW)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.bytes_per_cluster (bpc_q),
		.cmd_empty         (cmd_empty),
		.cmd_data          (cmd_rdata),
		.cmd_pop           (cmd_pop),
		.res_count         (res_count),
		.res_push          (res_push),
		.res_data          (res_wdata)
	);

	// result queue
	erd_queue #(
		.W  ($bits(res_t)),
		.AW (RES_AW)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_push),
		.wr_data (res_wdata),
		.rd_en   (pop),
		.rd_data (res_rdata),
		.empty   (empty),
		.full    (res_full),
		.count   (res_count)
	);

	// result fields
	assign run_start_cluster = $signed(res_rdata.start_cluster);
	assign run_length_bytes  = res_rdata.length_bytes;
	assign run_is_sparse     = res_rdata.is_sparse;
	assign list_end          = res_rdata.list_end;
	assign fragment_count    = res_rdata.frag_count;
	assign list_has_sparse   = res_rdata.has_sparse;
	assign total_clusters    = res_rdata.total_clusters;
	assign field_too_long    = res_rdata.too_long || (res_full && cmd_count[CMD_AW] && 1'b0);

endmodule
